// ----- hw/rtl/apm_pkg.sv -----
// Shared types and constants for the approximate pattern matcher.
package apm_pkg;

    localparam int DIST_W    = 5;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 64;
    localparam int PAT_BYTES = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ERRORS     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 8'd3;

    typedef struct packed {
        logic [7:0] text_char;
        logic       text_start;
    } t_in_item;

    typedef struct packed {
        logic              is_match;
        logic [31:0]       text_position;
        logic [DIST_W-1:0] distance;
    } t_out_item;

    typedef struct packed {
        logic [DIST_W-1:0]          pattern_length;
        logic [DIST_W-1:0]          max_errors;
        logic [PAT_BYTES-1:0][7:0] pattern;
    } t_cfg;

endpackage

// ----- hw/rtl/apm_cfg_regs.sv -----
// Configuration register file for the approximate pattern matcher.
module apm_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr_en,
    input  logic [apm_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [apm_pkg::CFG_DAT_W-1:0]  i_data,
    output apm_pkg::t_cfg                   o_cfg
);
    import apm_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_length <= DIST_W'(1);
            r_cfg.max_errors     <= '0;
            r_cfg.pattern        <= '0;
        end else if (i_wr_en) begin
            case (i_index)
                REG_PATTERN_LENGTH: r_cfg.pattern_length <= i_data[DIST_W-1:0];
                REG_MAX_ERRORS:     r_cfg.max_errors     <= i_data[DIST_W-1:0];
                REG_PATTERN_LOW:    r_cfg.pattern[7:0]   <= i_data;
                REG_PATTERN_HIGH:   r_cfg.pattern[15:8]  <= i_data;
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/apm_cell.sv -----
// Shared edit-distance cell: one column entry of the unit-cost recurrence.
module apm_cell (
    input  logic [apm_pkg::DIST_W-1:0] i_old,
    input  logic [apm_pkg::DIST_W-1:0] i_diag_old,
    input  logic [apm_pkg::DIST_W-1:0] i_up,
    input  logic [7:0]                 i_pat_char,
    input  logic [7:0]                 i_text_char,
    input  logic [apm_pkg::DIST_W-1:0] i_cap,
    output logic [apm_pkg::DIST_W-1:0] o_new
);
    import apm_pkg::*;

    logic [DIST_W:0] w_del;
    logic [DIST_W:0] w_ins;
    logic [DIST_W:0] w_diag;
    logic [DIST_W:0] w_m0;
    logic [DIST_W:0] w_m1;
    logic [DIST_W:0] w_m2;

    always_comb begin
        w_del  = {1'b0, i_old} + 1'b1;
        w_ins  = {1'b0, i_up} + 1'b1;
        w_diag = {1'b0, i_diag_old} + {{DIST_W{1'b0}}, (i_pat_char != i_text_char)};
        w_m0   = (w_del < w_ins) ? w_del : w_ins;
        w_m1   = (w_m0 < w_diag) ? w_m0 : w_diag;
        w_m2   = (w_m1 < {1'b0, i_cap}) ? w_m1 : {1'b0, i_cap};
        o_new  = w_m2[DIST_W-1:0];
    end

endmodule

// ----- hw/rtl/approximate_pattern_matcher.sv -----
// Top level of the approximate pattern matcher: sequencer, column store, result register.
//
// Usage: load the pattern, its length and the error budget through the
// configuration channel (index 0 pattern_length, 1 max_errors, 2 pattern bytes
// 0-7, 3 pattern bytes 8-15) while the block is idle. Then stream text bytes on
// the input channel; set text_start on the first byte of each text to restart
// the edit-distance column and the position count at zero.
// Every text byte yields exactly one result item: the capped distance of the
// pattern ending at that byte, the byte's position and a match flag.
// Sweep: one shared cell updates column entries 1..MAX_PATTERN, one per cycle,
// and the result then goes from the sequencer to the result register. Input
// ready is low during the sweep and until that result has left the sequencer,
// so a new item is taken only after the last one is through the sweep.
// Stall: a result waits in the output register; the next item may already be
// accepted and swept, and its result is held in the sequencer until the output
// register frees up. Reset restores the configuration defaults, the column to
// entry i = i and the position counter to zero.
module approximate_pattern_matcher #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  apm_pkg::t_in_item               i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output apm_pkg::t_out_item              o_out_item,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [apm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [apm_pkg::CFG_DAT_W-1:0]  i_cfg_data
);
    import apm_pkg::*;

    localparam int IW = $clog2(MAX_PATTERN + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [IW-1:0]       r_idx;
    logic [DIST_W-1:0]   r_col [1:MAX_PATTERN];
    logic [DIST_W-1:0]   r_prev;
    logic [DIST_W-1:0]   r_up;
    logic [DIST_W-1:0]   r_dist;
    logic [7:0]          r_char;
    logic                r_start;
    logic [31:0]         r_pos;
    logic [31:0]         r_item_pos;
    logic                r_out_valid;
    t_out_item           r_out_item;

    t_cfg                w_cfg;
    logic [IW-1:0]       w_len;
    logic [DIST_W-1:0]   w_err;
    logic [DIST_W-1:0]   w_cap;
    logic [DIST_W-1:0]   w_old;
    logic [DIST_W-1:0]   w_new;
    logic [7:0]          w_pat_char;
    logic                w_in_acc;
    logic                w_out_free;

    apm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    always_comb begin
        w_len = (32'(w_cfg.pattern_length) > 32'(MAX_PATTERN))
              ? IW'(MAX_PATTERN) : IW'(w_cfg.pattern_length);
        w_err = (32'(w_cfg.max_errors) > 32'(MAX_PATTERN))
              ? DIST_W'(MAX_PATTERN) : w_cfg.max_errors;
        w_cap = w_err + 1'b1;
        // a new text restarts from the initial column without clearing the store
        w_old = r_start ? DIST_W'(r_idx) : r_col[r_idx];
        w_pat_char = w_cfg.pattern[4'(r_idx - 1'b1)];
    end

    apm_cell u_cell (
        .i_old       (w_old),
        .i_diag_old  (r_prev),
        .i_up        (r_up),
        .i_pat_char  (w_pat_char),
        .i_text_char (r_char),
        .i_cap       (w_cap),
        .o_new       (w_new)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= IW'(1);
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            r_start     <= 1'b0;
            for (int k = 1; k <= MAX_PATTERN; k++) begin
                r_col[k] <= DIST_W'(k);
            end
        end else begin
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_char  <= i_in_item.text_char;
                        r_start <= i_in_item.text_start;
                        r_prev  <= '0;
                        r_up    <= '0;
                        r_dist  <= '0;
                        r_idx   <= IW'(1);
                        if (i_in_item.text_start) begin
                            r_item_pos <= '0;
                            r_pos      <= 32'd1;
                        end else begin
                            r_item_pos <= r_pos;
                            r_pos      <= r_pos + 32'd1;
                        end
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_col[r_idx] <= w_new;
                    r_prev       <= w_old;
                    r_up         <= w_new;
                    if (r_idx == w_len) begin
                        r_dist <= w_new;
                    end
                    if (r_idx == IW'(MAX_PATTERN)) begin
                        r_start <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DONE: begin
                    // hold the result until the output register frees up
                    if (w_out_free) begin
                        r_out_valid              <= 1'b1;
                        r_out_item.is_match      <= (r_dist <= w_err);
                        r_out_item.text_position <= r_item_pos;
                        r_out_item.distance      <= r_dist;
                        r_state                  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_idx != '0 && 32'(r_idx) <= MAX_PATTERN))
        else $error("column index out of range during sweep");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted again during sweep");

    a_dist_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out_item.distance) <= MAX_PATTERN))
        else $error("distance exceeds pattern capacity");

    a_load_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !i_out_ready) |=> (r_state == S_DONE))
        else $error("result left sequencer while output register was full");

endmodule
